[design/dca_pkg.sv]
// ----------------------------------------------------------------------------
// DMA channel allocator package
// Shared types, codes and default sizes for the channel allocator.
// ----------------------------------------------------------------------------
package dca_pkg;

  // Field widths of the transfer payloads.
  localparam int ID_W   = 8;
  localparam int MASK_W = 2;
  localparam int CH_W   = 1;
  localparam int OUT_W  = 3;

  // Default sizes.
  localparam int DEF_CHANNELS    = 2;
  localparam int DEF_QUEUE_DEPTH = 16;

  // Input action codes.
  typedef enum logic [0:0] {
    ACT_REQUEST = 1'b0,
    ACT_FREE    = 1'b1
  } action_t;

  // Result outcome codes.
  typedef enum logic [OUT_W-1:0] {
    OC_GRANTED    = 3'd0,
    OC_QUEUED     = 3'd1,
    OC_REJECTED   = 3'd2,
    OC_HANDED     = 3'd3,
    OC_FREED_IDLE = 3'd4
  } outcome_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_SHIFT,
    ST_EMIT
  } state_t;

  // One entry of the wait list.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [MASK_W-1:0] mask;
  } wait_ent_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic decide;
    logic scan;
    logic shift;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scan;
    logic hit;
    logic scan_end;
    logic shift_end;
  } sts_t;

endpackage

[design/dca_ifs.sv]
// ----------------------------------------------------------------------------
// DMA channel allocator channel interfaces
// Valid/ready interfaces for the request/free channel and the result channel.
// ----------------------------------------------------------------------------
interface dca_in_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [dca_pkg::ID_W-1:0]   requester_id;
  logic [dca_pkg::MASK_W-1:0] channel_mask;
  logic [dca_pkg::CH_W-1:0]   free_channel;

  modport source (output valid, action, requester_id, channel_mask, free_channel,
                  input ready);
  modport sink (input valid, action, requester_id, channel_mask, free_channel,
                output ready);
endinterface

interface dca_out_if;
  logic                     valid;
  logic                     ready;
  logic [dca_pkg::OUT_W-1:0] outcome;
  logic [dca_pkg::CH_W-1:0]  channel;
  logic [dca_pkg::ID_W-1:0]  requester_id_res;

  modport source (output valid, outcome, channel, requester_id_res, input ready);
  modport sink (input valid, outcome, channel, requester_id_res, output ready);
endinterface

[design/dma_channel_allocator.sv]
// ----------------------------------------------------------------------------
// DMA channel allocator
// Grants DMA channels to requesters, keeps a FIFO wait list of requests that
// cannot be served, and hands a freed channel to the oldest matching waiter.
//
//   Channel  Direction  Handshake        Payload
//   in_chan  sink       valid / ready    action, requester_id, channel_mask,
//                                        free_channel
//   out_chan source     valid / ready    outcome, channel, requester_id_res
//
// A request is captured, decided and then loaded into the output register, which offers its result.
// A free is captured and decided, then scans the wait list (one entry per cycle)
// and, on a match, compacts the list behind the removed waiter (one entry per
// cycle); the single memory port pair of the wait list sets this rate.
// One transfer is worked on at a time; the next is accepted once the result
// of the previous one has moved into the output register, even while that
// result waits for out_chan.ready.
// Reset is synchronous and active low and leaves all channels idle and the
// wait list empty.
// ----------------------------------------------------------------------------
module dma_channel_allocator #(
  parameter int CHANNELS    = dca_pkg::DEF_CHANNELS,
  parameter int QUEUE_DEPTH = dca_pkg::DEF_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  dca_in_if.sink    in_chan,
  dca_out_if.source out_chan
);

  dca_pkg::cmd_t cmd;
  dca_pkg::sts_t sts;

  // Sequencer.
  dca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Channel state, wait list and result registers.
  dca_dpath #(
    .CHANNELS    (CHANNELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_action            (in_chan.action),
    .in_requester_id      (in_chan.requester_id),
    .in_channel_mask      (in_chan.channel_mask),
    .in_free_channel      (in_chan.free_channel),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_outcome          (out_chan.outcome),
    .out_channel          (out_chan.channel),
    .out_requester_id_res (out_chan.requester_id_res)
  );

endmodule

[design/dca_ctrl.sv]
// ----------------------------------------------------------------------------
// DMA channel allocator controller
// Sequencer that steps one transfer through decide, wait-list scan, wait-list
// compaction and result hand-off, and owns the result valid flag.
// ----------------------------------------------------------------------------
module dca_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  input  dca_pkg::sts_t sts,
  output dca_pkg::cmd_t cmd
);

  dca_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  // The result register can take a new value when empty or being drained.
  assign out_free = !out_valid_r || out_ready;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dca_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = dca_pkg::ST_DECIDE;
      end
      dca_pkg::ST_DECIDE: begin
        state_nxt = sts.need_scan ? dca_pkg::ST_SCAN : dca_pkg::ST_EMIT;
      end
      dca_pkg::ST_SCAN: begin
        priority if (sts.hit)      state_nxt = dca_pkg::ST_SHIFT;
        else if (sts.scan_end)     state_nxt = dca_pkg::ST_EMIT;
        else                       state_nxt = dca_pkg::ST_SCAN;
      end
      dca_pkg::ST_SHIFT: begin
        if (sts.shift_end) state_nxt = dca_pkg::ST_EMIT;
      end
      dca_pkg::ST_EMIT: begin
        if (out_free) state_nxt = dca_pkg::ST_IDLE;
      end
      default: state_nxt = dca_pkg::ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state_r)
      dca_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      dca_pkg::ST_DECIDE: cmd.decide   = 1'b1;
      dca_pkg::ST_SCAN:   cmd.scan     = 1'b1;
      dca_pkg::ST_SHIFT:  cmd.shift    = 1'b1;
      dca_pkg::ST_EMIT:   cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

  // Result valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready)        out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dca_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A loaded result is offered in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("result load did not raise valid");

  // A new transfer is never taken while one is in progress.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && in_valid) |=> (state_r == dca_pkg::ST_DECIDE))
    else $error("accepted transfer did not reach decide");

  // The result register is never overwritten while it still holds a result.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && out_valid_r) |-> out_ready)
    else $error("pending result overwritten");

endmodule

[design/dca_dpath.sv]
// ----------------------------------------------------------------------------
// DMA channel allocator datapath
// Busy bits, wait-list memory with its count, scan pointer and result
// registers. One memory read and one memory write per cycle.
// ----------------------------------------------------------------------------
module dca_dpath #(
  parameter int CHANNELS    = dca_pkg::DEF_CHANNELS,
  parameter int QUEUE_DEPTH = dca_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_action,
  input  logic [dca_pkg::ID_W-1:0]   in_requester_id,
  input  logic [dca_pkg::MASK_W-1:0] in_channel_mask,
  input  logic [dca_pkg::CH_W-1:0]   in_free_channel,
  input  dca_pkg::cmd_t              cmd,
  output dca_pkg::sts_t              sts,
  output logic [dca_pkg::OUT_W-1:0]  out_outcome,
  output logic [dca_pkg::CH_W-1:0]   out_channel,
  output logic [dca_pkg::ID_W-1:0]   out_requester_id_res
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Captured transfer.
  dca_pkg::action_t            act_r;
  logic [dca_pkg::ID_W-1:0]    id_r;
  logic [dca_pkg::MASK_W-1:0]  mask_r;
  logic [dca_pkg::CH_W-1:0]    fch_r;

  // Control state.
  logic [CHANNELS-1:0] busy_r, busy_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       ptr_r, ptr_nxt;
  logic                pend_r, pend_nxt;

  // Wait-list memory and its read pipeline.
  dca_pkg::wait_ent_t  mem [QUEUE_DEPTH];
  dca_pkg::wait_ent_t  rd_data_r;
  logic [AW-1:0]       tag_r;

  // Result and output registers.
  dca_pkg::outcome_t           res_oc_r;
  logic [dca_pkg::CH_W-1:0]    res_ch_r;
  logic [dca_pkg::ID_W-1:0]    res_id_r;
  logic [dca_pkg::OUT_W-1:0]   out_oc_r;
  logic [dca_pkg::CH_W-1:0]    out_ch_r;
  logic [dca_pkg::ID_W-1:0]    out_id_r;

  logic [dca_pkg::MASK_W-1:0]  busy_view;
  logic [dca_pkg::MASK_W-1:0]  ch_exist;
  logic [dca_pkg::MASK_W-1:0]  avail;
  logic                        grant_any;
  logic [dca_pkg::CH_W-1:0]    grant_ch;
  logic                        full;
  logic                        is_free;
  logic                        fch_ok;
  logic                        hit;
  logic                        at_end;
  logic                        rd_issue;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  dca_pkg::wait_ent_t          wr_data;
  logic                        set_en;
  logic [dca_pkg::CH_W-1:0]    set_ch;
  logic                        clr_en;

  // Channel numbers that the mask can name but the block does not have read
  // as permanently busy and absent.
  for (genvar g = 0; g < dca_pkg::MASK_W; g++) begin : g_view
    if (g < CHANNELS) begin : g_real
      assign busy_view[g] = busy_r[g];
      assign ch_exist[g]  = 1'b1;
    end else begin : g_none
      assign busy_view[g] = 1'b1;
      assign ch_exist[g]  = 1'b0;
    end
  end

  // Grant selection: highest-numbered idle channel in the mask.
  assign avail     = mask_r & ~busy_view;
  assign grant_any = |avail;
  assign grant_ch  = avail[1];
  assign full      = (count_r == CW'(QUEUE_DEPTH));
  assign is_free   = (act_r == dca_pkg::ACT_FREE);
  assign fch_ok    = ch_exist[fch_r];

  // Scan and compaction status.
  assign hit    = pend_r && rd_data_r.mask[fch_r];
  assign at_end = (ptr_r == count_r);

  assign sts.need_scan = is_free && fch_ok;
  assign sts.hit       = hit;
  assign sts.scan_end  = !hit && at_end;
  assign sts.shift_end = at_end;

  // Memory port control. Compaction writes each entry it has read back one
  // place lower in the list.
  assign rd_issue = (cmd.scan && !hit && !at_end) || (cmd.shift && !at_end);
  assign wr_en    = (cmd.decide && !is_free && !grant_any && !full) ||
                    (cmd.shift && pend_r);
  assign wr_addr  = cmd.shift ? (tag_r - AW'(1)) : count_r[AW-1:0];
  assign wr_data  = cmd.shift ? rd_data_r : dca_pkg::wait_ent_t'{id: id_r, mask: mask_r};

  // Busy bit updates.
  assign set_en = (cmd.decide && !is_free && grant_any) || (cmd.scan && hit);
  assign set_ch = cmd.decide ? grant_ch : fch_r;
  assign clr_en = cmd.decide && is_free && fch_ok;

  // Next values of the control state.
  always_comb begin
    busy_nxt  = busy_r;
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    pend_nxt  = pend_r;
    for (int i = 0; i < CHANNELS; i++) begin
      if (clr_en && (int'(fch_r) == i)) busy_nxt[i] = 1'b0;
      if (set_en && (int'(set_ch) == i)) busy_nxt[i] = 1'b1;
    end
    if (cmd.decide) begin
      if (!is_free && !grant_any && !full) count_nxt = count_r + CW'(1);
      ptr_nxt  = '0;
      pend_nxt = 1'b0;
    end
    if (cmd.scan) begin
      priority if (hit) begin
        pend_nxt = 1'b0;
      end else if (!at_end) begin
        ptr_nxt  = ptr_r + CW'(1);
        pend_nxt = 1'b1;
      end else begin
        pend_nxt = 1'b0;
      end
    end
    if (cmd.shift) begin
      if (!at_end) begin
        ptr_nxt  = ptr_r + CW'(1);
        pend_nxt = 1'b1;
      end else begin
        pend_nxt  = 1'b0;
        count_nxt = count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= '0;
      count_r <= '0;
      ptr_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Capture of the accepted transfer.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r  <= dca_pkg::action_t'(in_action);
      id_r   <= in_requester_id;
      mask_r <= in_channel_mask;
      fch_r  <= in_free_channel;
    end
  end

  // Wait-list memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_issue) begin
      rd_data_r <= mem[ptr_r[AW-1:0]];
      tag_r     <= ptr_r[AW-1:0];
    end
  end

  // Result formation and output register.
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      res_id_r <= id_r;
      priority if (is_free) begin
        res_oc_r <= dca_pkg::OC_FREED_IDLE;
        res_ch_r <= fch_r;
      end else if (grant_any) begin
        res_oc_r <= dca_pkg::OC_GRANTED;
        res_ch_r <= grant_ch;
      end else if (full) begin
        res_oc_r <= dca_pkg::OC_REJECTED;
        res_ch_r <= '0;
      end else begin
        res_oc_r <= dca_pkg::OC_QUEUED;
        res_ch_r <= '0;
      end
    end
    if (cmd.scan && hit) begin
      res_oc_r <= dca_pkg::OC_HANDED;
      res_ch_r <= fch_r;
      res_id_r <= rd_data_r.id;
    end
    if (cmd.load_out) begin
      out_oc_r <= res_oc_r;
      out_ch_r <= res_ch_r;
      out_id_r <= res_id_r;
    end
  end

  assign out_outcome          = out_oc_r;
  assign out_channel          = out_ch_r;
  assign out_requester_id_res = out_id_r;

  // The wait count never exceeds the list depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("wait count beyond depth");

  // The scan pointer stays within the occupied part of the list.
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan || cmd.shift) |-> (ptr_r <= count_r))
    else $error("scan pointer beyond wait count");

  // Compaction only runs on a list that holds the removed waiter.
  a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift |-> (count_r != '0))
    else $error("compaction on empty list");

  // A channel handed to a waiter is busy afterwards.
  a_handed_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan && hit) |=> busy_view[fch_r])
    else $error("handed channel not marked busy");

endmodule
